### rtl/zmpip_pkg.sv
// ----------------------------------------------------------------------------
// zmpip_pkg
// Shared constants for the zone mask point-in-polygon block.
// ----------------------------------------------------------------------------
package zmpip_pkg;

    localparam int ZMPIP_MAX_ZONES    = 16;
    localparam int ZMPIP_MAX_VERTICES = 256;

    localparam int Q_W   = 15;   // Q7.8 coordinate
    localparam int PIX_W = 12;
    localparam int SZ_W  = 13;

    localparam logic [SZ_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [SZ_W-1:0] HEIGHT_RESET = 13'd480;

    // register index taken from paddr[2]
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_RECT   = 2'd1;
    localparam logic [1:0] CMD_VERTEX = 2'd2;
    localparam logic [1:0] CMD_TEST   = 2'd3;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_ZONE_FULL   = 2'd1;
    localparam logic [1:0] ST_VERTEX_FULL = 2'd2;

endpackage

### rtl/zone_mask_point_in_polygon.sv
// ----------------------------------------------------------------------------
// zone_mask_point_in_polygon
// Region-of-interest mask: zone table load and per-pixel zone membership test.
//
//   channel  dir  handshake                    content
//   s_axis   in   s_tvalid / s_tready          command item (load or pixel test)
//   m_axis   out  m_tvalid / m_tready          mask bit and status, one per request
//   apb      in   psel/penable/pwrite/pready   image width and height
//
// A pixel test first runs the two radix-2 percent dividers, then walks
// the zones and the vertices of each polygon (zone and vertex memories
// are read one entry at a time), ending early at the first zone that
// holds the pixel.
// Reset is synchronous; the zone table is empty after it, no clearing pass.
// The next request is taken while a result waits in the output register;
// a stalled output holds the block only when a second result is ready.
// ----------------------------------------------------------------------------
module zone_mask_point_in_polygon
    import zmpip_pkg::SZ_W;
#(
    parameter int MAX_ZONES    = zmpip_pkg::ZMPIP_MAX_ZONES,
    parameter int MAX_VERTICES = zmpip_pkg::ZMPIP_MAX_VERTICES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // cmd[1:0] new_contour[2] pixel_x[14:3] pixel_y[26:15] first_x[41:27]
    // first_y[56:42] second_x[71:57] second_y[86:72], zero fill
    input  logic [87:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // mask_bit[0] status[2:1], zero fill
    output logic [7:0]  m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import zmpip_pkg::*;

    localparam int ZA  = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
    localparam int ZC  = $clog2(MAX_ZONES + 1);
    localparam int VA  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int VC  = $clog2(MAX_VERTICES + 1);
    localparam int ZEW = 1 + 4 * Q_W + VA + VC;
    localparam int VEW = 2 * Q_W;
    localparam int NW  = 20;   // 200*pixel + size
    localparam int DW  = 14;   // 2*size
    localparam int RW  = 15;
    localparam int SW  = 30;   // signed compare width
    localparam int PW  = 2 * SW;
    localparam int CW  = $clog2(NW);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_DIV  = 9'b000000010,
        S_ZRD  = 9'b000000100,
        S_ZCHK = 9'b000001000,
        S_VRD  = 9'b000010000,
        S_VDAT = 9'b000100000,
        S_EMUL = 9'b001000000,
        S_EVAL = 9'b010000000,
        S_DONE = 9'b100000000
    } state_t;

    state_t state_reg;

    logic [SZ_W-1:0] width_reg, height_reg;
    logic [ZC-1:0]   zone_count_reg;
    logic [VC-1:0]   vertex_total_reg;
    logic            last_rect_reg;
    logic [VA-1:0]   last_first_reg;
    logic [VC-1:0]   last_vcount_reg;

    logic [NW-1:0]   nx_reg, ny_reg;
    logic [DW-1:0]   dx_reg, dy_reg;
    logic [RW-1:0]   remx_reg, remy_reg;
    logic [CW-1:0]   div_cnt_reg;

    logic [ZC-1:0]   zidx_reg;
    logic [VA-1:0]   first_reg;
    logic [VC-1:0]   nvert_reg;
    logic [VC-1:0]   vidx_reg;
    logic [VEW-1:0]  v0_reg, prev_reg, ei_reg, ej_reg;
    logic            closing_reg;
    logic            parity_reg;
    logic            hit_reg, cross_reg, dypos_reg;
    logic signed [PW-1:0] lhs_reg, rhs_reg;

    logic            res_mask_reg;
    logic [1:0]      res_status_reg;
    logic            m_valid_reg, m_mask_reg;
    logic [1:0]      m_status_reg;

    // input fields
    logic [1:0]       in_cmd;
    logic             in_nc;
    logic [PIX_W-1:0] in_px, in_py;
    logic [Q_W-1:0]   in_fx, in_fy, in_sx, in_sy;

    assign in_cmd = s_tdata[1:0];
    assign in_nc  = s_tdata[2];
    assign in_px  = s_tdata[14:3];
    assign in_py  = s_tdata[26:15];
    assign in_fx  = s_tdata[41:27];
    assign in_fy  = s_tdata[56:42];
    assign in_sx  = s_tdata[71:57];
    assign in_sy  = s_tdata[86:72];

    logic accept;
    logic test_walk;
    logic out_free;
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign test_walk = (in_cmd == CMD_TEST) && (zone_count_reg != '0);
    assign out_free  = !m_valid_reg || m_tready;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    logic cfg_we;
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[2])
            REG_IMAGE_WIDTH:  prdata = {{(32 - SZ_W){1'b0}}, width_reg};
            REG_IMAGE_HEIGHT: prdata = {{(32 - SZ_W){1'b0}}, height_reg};
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // memories
    // ------------------------------------------------------------------
    logic            zwe, vwe;
    logic [ZA-1:0]   zwaddr;
    logic [ZEW-1:0]  zwdata, zrdata;
    logic [VA-1:0]   vwaddr, vraddr;
    logic [VEW-1:0]  vwdata, vrdata;
    logic [VC:0]     vsum;

    assign vsum   = (VC + 1)'(first_reg) + (VC + 1)'(vidx_reg);
    assign vraddr = vsum[VA-1:0];

    zmpip_ram #(.WIDTH(ZEW), .DEPTH(MAX_ZONES), .AW(ZA)) u_zone_ram (
        .aclk  (aclk),
        .we    (zwe),
        .waddr (zwaddr),
        .wdata (zwdata),
        .raddr (zidx_reg[ZA-1:0]),
        .rdata (zrdata)
    );

    zmpip_ram #(.WIDTH(VEW), .DEPTH(MAX_VERTICES), .AW(VA)) u_vertex_ram (
        .aclk  (aclk),
        .we    (vwe),
        .waddr (vwaddr),
        .wdata (vwdata),
        .raddr (vraddr),
        .rdata (vrdata)
    );

    // ------------------------------------------------------------------
    // load requests
    // ------------------------------------------------------------------
    logic          open_zone, zone_full, vert_full;
    logic          ld_ok;
    logic [1:0]    ld_status;
    logic [VA-1:0] zv_first;
    logic [VC-1:0] zv_cnt;

    assign open_zone = in_nc || (zone_count_reg == '0) || last_rect_reg;
    assign zone_full = (zone_count_reg == ZC'(MAX_ZONES));
    assign vert_full = (vertex_total_reg == VC'(MAX_VERTICES));
    assign zv_first  = open_zone ? vertex_total_reg[VA-1:0] : last_first_reg;
    assign zv_cnt    = open_zone ? VC'(1) : last_vcount_reg + VC'(1);

    always_comb begin
        zwe       = 1'b0;
        zwaddr    = zone_count_reg[ZA-1:0];
        zwdata    = {1'b1, {(VC + VA){1'b0}}, in_sy, in_sx, in_fy, in_fx};
        vwe       = 1'b0;
        vwaddr    = vertex_total_reg[VA-1:0];
        vwdata    = {in_fy, in_fx};
        ld_ok     = 1'b0;
        ld_status = ST_OK;
        if (accept) begin
            case (in_cmd)
                CMD_RECT: begin
                    if (zone_full) begin
                        ld_status = ST_ZONE_FULL;
                    end else begin
                        zwe   = 1'b1;
                        ld_ok = 1'b1;
                    end
                end
                CMD_VERTEX: begin
                    if (open_zone && zone_full) begin
                        ld_status = ST_ZONE_FULL;
                    end else if (vert_full) begin
                        ld_status = ST_VERTEX_FULL;
                    end else begin
                        ld_ok  = 1'b1;
                        vwe    = 1'b1;
                        zwe    = 1'b1;
                        zwdata = {1'b0, zv_cnt, zv_first, {(4 * Q_W){1'b0}}};
                        if (!open_zone) begin
                            zwaddr = ZA'(zone_count_reg - ZC'(1));
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // percent dividers, one quotient bit per cycle
    // ------------------------------------------------------------------
    logic [SZ_W-1:0] wsz, hsz;
    logic [RW-1:0]   shx, shy;
    logic            gex, gey;

    assign wsz = (width_reg == '0) ? SZ_W'(1) : width_reg;
    assign hsz = (height_reg == '0) ? SZ_W'(1) : height_reg;
    assign shx = {remx_reg[RW-2:0], nx_reg[NW-1]};
    assign shy = {remy_reg[RW-2:0], ny_reg[NW-1]};
    assign gex = shx >= RW'(dx_reg);
    assign gey = shy >= RW'(dy_reg);

    // ------------------------------------------------------------------
    // zone and edge tests
    // ------------------------------------------------------------------
    logic signed [SW-1:0] px_s, py_s;
    logic signed [SW-1:0] rl, rt, rr, rb;
    logic signed [SW-1:0] xi, yi, xj, yj, xtop;
    logic [Q_W-1:0]       xlo_u, ylo_u, yhi_u;
    logic                 rect_in;
    logic                 e_skip, e_top, e_vert;
    logic                 cross_hit, edge_hit;
    logic                 zone_last;

    assign px_s = signed'(SW'({nx_reg, 8'b0}));
    assign py_s = signed'(SW'({ny_reg, 8'b0}));

    assign rl = signed'(SW'(zrdata[Q_W-1:0]));
    assign rt = signed'(SW'(zrdata[2*Q_W-1:Q_W]));
    assign rr = signed'(SW'(zrdata[3*Q_W-1:2*Q_W]));
    assign rb = signed'(SW'(zrdata[4*Q_W-1:3*Q_W]));
    assign rect_in = (px_s > rl) && (px_s < rr) && (py_s > rt) && (py_s < rb);

    assign xi = signed'(SW'(ei_reg[Q_W-1:0]));
    assign yi = signed'(SW'(ei_reg[2*Q_W-1:Q_W]));
    assign xj = signed'(SW'(ej_reg[Q_W-1:0]));
    assign yj = signed'(SW'(ej_reg[2*Q_W-1:Q_W]));
    assign xlo_u = (xi < xj) ? ei_reg[Q_W-1:0] : ej_reg[Q_W-1:0];
    assign ylo_u = (yi < yj) ? ei_reg[2*Q_W-1:Q_W] : ej_reg[2*Q_W-1:Q_W];
    assign yhi_u = (yi < yj) ? ej_reg[2*Q_W-1:Q_W] : ei_reg[2*Q_W-1:Q_W];
    assign xtop  = (yi > yj) ? xi : xj;

    assign e_skip = (ei_reg[2*Q_W-1:Q_W+8] == ej_reg[2*Q_W-1:Q_W+8])
                 || ((yi > py_s) && (yj > py_s))
                 || ((yi < py_s) && (yj < py_s))
                 || (NW'(xlo_u[Q_W-1:8]) > nx_reg)
                 || (NW'(ylo_u[Q_W-1:8]) == ny_reg);
    assign e_top  = (NW'(yhi_u[Q_W-1:8]) == ny_reg);
    assign e_vert = (xi == xj);

    assign cross_hit = dypos_reg ? (lhs_reg < rhs_reg) : (lhs_reg > rhs_reg);
    assign edge_hit  = cross_reg ? cross_hit : hit_reg;
    assign zone_last = ((zidx_reg + ZC'(1)) == zone_count_reg);

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            width_reg        <= WIDTH_RESET;
            height_reg       <= HEIGHT_RESET;
            zone_count_reg   <= '0;
            vertex_total_reg <= '0;
            last_rect_reg    <= 1'b0;
            last_first_reg   <= '0;
            last_vcount_reg  <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (paddr[2])
                    REG_IMAGE_WIDTH:  width_reg  <= pwdata[SZ_W-1:0];
                    REG_IMAGE_HEIGHT: height_reg <= pwdata[SZ_W-1:0];
                    default: begin
                    end
                endcase
            end

            if ((state_reg == S_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        res_mask_reg   <= (in_cmd == CMD_TEST) && (zone_count_reg == '0);
                        res_status_reg <= ld_status;
                        state_reg      <= test_walk ? S_DIV : S_DONE;
                        case (in_cmd)
                            CMD_CLEAR: begin
                                zone_count_reg   <= '0;
                                vertex_total_reg <= '0;
                            end
                            CMD_RECT: begin
                                if (ld_ok) begin
                                    zone_count_reg <= zone_count_reg + ZC'(1);
                                    last_rect_reg  <= 1'b1;
                                end
                            end
                            CMD_VERTEX: begin
                                if (ld_ok) begin
                                    if (open_zone) begin
                                        zone_count_reg <= zone_count_reg + ZC'(1);
                                    end
                                    vertex_total_reg <= vertex_total_reg + VC'(1);
                                    last_rect_reg    <= 1'b0;
                                    last_first_reg   <= zv_first;
                                    last_vcount_reg  <= zv_cnt;
                                end
                            end
                            CMD_TEST: begin
                                if (test_walk) begin
                                    // floor(100*v/size + 0.5) = (200*v + s) / (2*s)
                                    nx_reg <= NW'({in_px, 7'b0}) + NW'({in_px, 6'b0})
                                            + NW'({in_px, 3'b0}) + NW'(wsz);
                                    ny_reg <= NW'({in_py, 7'b0}) + NW'({in_py, 6'b0})
                                            + NW'({in_py, 3'b0}) + NW'(hsz);
                                    dx_reg      <= {wsz, 1'b0};
                                    dy_reg      <= {hsz, 1'b0};
                                    remx_reg    <= '0;
                                    remy_reg    <= '0;
                                    div_cnt_reg <= '0;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    remx_reg    <= gex ? shx - RW'(dx_reg) : shx;
                    remy_reg    <= gey ? shy - RW'(dy_reg) : shy;
                    nx_reg      <= {nx_reg[NW-2:0], gex};
                    ny_reg      <= {ny_reg[NW-2:0], gey};
                    div_cnt_reg <= div_cnt_reg + CW'(1);
                    if (div_cnt_reg == CW'(NW - 1)) begin
                        zidx_reg  <= '0;
                        state_reg <= S_ZRD;
                    end
                end
                S_ZRD: begin
                    state_reg <= S_ZCHK;
                end
                S_ZCHK: begin
                    if (zrdata[ZEW-1]) begin
                        if (rect_in) begin
                            res_mask_reg <= 1'b1;
                            state_reg    <= S_DONE;
                        end else if (zone_last) begin
                            state_reg <= S_DONE;
                        end else begin
                            zidx_reg  <= zidx_reg + ZC'(1);
                            state_reg <= S_ZRD;
                        end
                    end else begin
                        first_reg  <= zrdata[4*Q_W +: VA];
                        nvert_reg  <= zrdata[4*Q_W + VA +: VC];
                        vidx_reg   <= '0;
                        parity_reg <= 1'b0;
                        state_reg  <= S_VRD;
                    end
                end
                S_VRD: begin
                    state_reg <= S_VDAT;
                end
                S_VDAT: begin
                    prev_reg <= vrdata;
                    if (vidx_reg == '0) begin
                        v0_reg <= vrdata;
                        if (nvert_reg == VC'(1)) begin
                            ei_reg      <= vrdata;
                            ej_reg      <= vrdata;
                            closing_reg <= 1'b1;
                            state_reg   <= S_EMUL;
                        end else begin
                            vidx_reg  <= vidx_reg + VC'(1);
                            state_reg <= S_VRD;
                        end
                    end else begin
                        ei_reg      <= prev_reg;
                        ej_reg      <= vrdata;
                        closing_reg <= 1'b0;
                        state_reg   <= S_EMUL;
                    end
                end
                S_EMUL: begin
                    // register the classification and both cross products
                    hit_reg   <= !e_skip && (e_top ? (px_s > xtop) : e_vert);
                    cross_reg <= !e_skip && !e_top && !e_vert;
                    dypos_reg <= yj > yi;
                    lhs_reg   <= PW'(py_s - yj) * PW'(xj - xi);
                    rhs_reg   <= PW'(px_s - xj) * PW'(yj - yi);
                    state_reg <= S_EVAL;
                end
                S_EVAL: begin
                    parity_reg <= parity_reg ^ edge_hit;
                    if (closing_reg) begin
                        if (parity_reg ^ edge_hit) begin
                            res_mask_reg <= 1'b1;
                            state_reg    <= S_DONE;
                        end else if (zone_last) begin
                            state_reg <= S_DONE;
                        end else begin
                            zidx_reg  <= zidx_reg + ZC'(1);
                            state_reg <= S_ZRD;
                        end
                    end else if (vidx_reg == nvert_reg - VC'(1)) begin
                        // close the polygon back to its first vertex
                        ei_reg      <= prev_reg;
                        ej_reg      <= v0_reg;
                        closing_reg <= 1'b1;
                        state_reg   <= S_EMUL;
                    end else begin
                        vidx_reg  <= vidx_reg + VC'(1);
                        state_reg <= S_VRD;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // output payload, no reset needed
    always_ff @(posedge aclk) begin
        if ((state_reg == S_DONE) && out_free) begin
            m_mask_reg   <= res_mask_reg;
            m_status_reg <= res_status_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_status_reg, m_mask_reg};

endmodule

### rtl/zmpip_ram.sv
// ----------------------------------------------------------------------------
// zmpip_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module zmpip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the zone mask point-in-polygon block.
// Loads rectangle and polygon zones over the stream input, tests pixels
// against them, and compares every mask/status response with a local
// model of the zone table. Image size is changed over APB between phases.
// ----------------------------------------------------------------------------
module tb;
    import zmpip_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 1200;

    typedef struct packed {
        logic [1:0]  cmd;
        logic        nc;
        logic [11:0] px;
        logic [11:0] py;
        logic [14:0] fx;
        logic [14:0] fy;
        logic [14:0] sx;
        logic [14:0] sy;
        logic        typed;
        logic        mask;
        logic [1:0]  st;
    } row_t;

    typedef struct {
        logic       typed;
        logic       mask;
        logic [1:0] st;
    } resp_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    zone_mask_point_in_polygon dut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // local copy of the zone table
    int          img_w = 640, img_h = 480;
    int          n_zones, n_verts;
    bit          z_rect [ZMPIP_MAX_ZONES];
    logic [59:0] z_corner [ZMPIP_MAX_ZONES];
    int          z_first [ZMPIP_MAX_ZONES];
    int          z_nvert [ZMPIP_MAX_ZONES];
    logic [29:0] v_store [ZMPIP_MAX_VERTICES];

    resp_t       pending_q[$];
    resp_t       tag_q[$];
    int          errors, n_sent, n_tests, n_inside, n_zfull, n_vfull;
    int          idle_cycles, burst_left, gap_max;
    logic [15:0] stall_pat = 16'hFFFF;
    int          pat_pos;

    function automatic longint to_pct(int v, int size);
        longint s;
        s = (size == 0) ? 1 : size;
        return (longint'(v) * 200 + s) / (2 * s);
    endfunction

    function automatic bit poly_holds(longint x, longint y, int z);
        longint px, py, xi, yi, xj, yj, ylo, yhi, xlo, xtop, dy, lhs, rhs;
        int     cnt, j;
        logic [29:0] vi, vj;
        px = x * 256;
        py = y * 256;
        cnt = 0;
        for (int i = 0; i < z_nvert[z]; i++) begin
            j = (i + 1 == z_nvert[z]) ? 0 : i + 1;
            vi = v_store[(z_first[z] + i) % ZMPIP_MAX_VERTICES];
            vj = v_store[(z_first[z] + j) % ZMPIP_MAX_VERTICES];
            xi = vi[14:0]; yi = vi[29:15];
            xj = vj[14:0]; yj = vj[29:15];
            ylo = (yi < yj) ? yi : yj;
            yhi = (yi < yj) ? yj : yi;
            xlo = (xi < xj) ? xi : xj;
            if ((yi >>> 8) == (yj >>> 8)) continue;
            if (yi > py && yj > py) continue;
            if (yi < py && yj < py) continue;
            if ((xlo >>> 8) > x) continue;
            if ((ylo >>> 8) == y) continue;
            if ((yhi >>> 8) == y) begin
                xtop = (yi > yj) ? xi : xj;
                if (px > xtop) cnt++;
            end else if (xi == xj) begin
                cnt++;
            end else begin
                dy = yj - yi;
                lhs = (py - yj) * (xj - xi);
                rhs = (px - xj) * dy;
                if (dy > 0 ? lhs < rhs : lhs > rhs) cnt++;
            end
        end
        return cnt[0];
    endfunction

    function automatic resp_t apply_request(logic [87:0] d);
        resp_t  r;
        bit     open;
        longint x, y, l, t, rr, b;
        r = '{1'b0, 1'b0, ST_OK};
        case (d[1:0])
            CMD_CLEAR: begin
                n_zones = 0;
                n_verts = 0;
            end
            CMD_RECT: begin
                if (n_zones >= ZMPIP_MAX_ZONES) begin
                    r.st = ST_ZONE_FULL;
                end else begin
                    z_rect[n_zones] = 1'b1;
                    z_corner[n_zones] = {d[86:72], d[71:57], d[56:42], d[41:27]};
                    n_zones++;
                end
            end
            CMD_VERTEX: begin
                open = d[2] || n_zones == 0 || z_rect[(n_zones - 1) % ZMPIP_MAX_ZONES];
                if (open && n_zones >= ZMPIP_MAX_ZONES) begin
                    r.st = ST_ZONE_FULL;
                end else if (n_verts >= ZMPIP_MAX_VERTICES) begin
                    r.st = ST_VERTEX_FULL;
                end else begin
                    if (open) begin
                        z_rect[n_zones] = 1'b0;
                        z_first[n_zones] = n_verts;
                        z_nvert[n_zones] = 0;
                        n_zones++;
                    end
                    v_store[n_verts] = {d[56:42], d[41:27]};
                    n_verts++;
                    z_nvert[n_zones - 1]++;
                end
            end
            default: begin
                if (n_zones == 0) begin
                    r.mask = 1'b1;
                end else begin
                    x = to_pct(d[14:3], img_w);
                    y = to_pct(d[26:15], img_h);
                    for (int z = 0; z < n_zones; z++) begin
                        if (z_rect[z]) begin
                            l = z_corner[z][14:0];  t = z_corner[z][29:15];
                            rr = z_corner[z][44:30]; b = z_corner[z][59:45];
                            if (x * 256 > l && x * 256 < rr && y * 256 > t && y * 256 < b)
                                r.mask = 1'b1;
                        end else if (poly_holds(x, y, z)) begin
                            r.mask = 1'b1;
                        end
                        if (r.mask) break;
                    end
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $time);
        errors++;
    endtask

    // request and response monitor
    always @(posedge aclk) begin
        resp_t want, tag;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                tag = tag_q.pop_front();
                want = apply_request(s_tdata);
                if (tag.typed) begin
                    if (tag.mask != want.mask || tag.st != want.st)
                        report_mismatch("table row vs model mask/status",
                                        {want.mask, want.st}, {tag.mask, tag.st});
                    want = tag;
                end
                pending_q.push_back(want);
                if (s_tdata[1:0] == CMD_TEST) n_tests++;
            end
            if (m_tvalid && m_tready) begin
                if (pending_q.size() == 0) begin
                    report_mismatch("unexpected response", m_tdata, -1);
                end else begin
                    want = pending_q.pop_front();
                    if (m_tdata[0] != want.mask)
                        report_mismatch("mask_bit", m_tdata[0], want.mask);
                    if (m_tdata[2:1] != want.st)
                        report_mismatch("status", m_tdata[2:1], want.st);
                    if (m_tdata[0]) n_inside++;
                    if (m_tdata[2:1] == ST_ZONE_FULL) n_zfull++;
                    if (m_tdata[2:1] == ST_VERTEX_FULL) n_vfull++;
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // receiver stall pattern
    always @(posedge aclk) begin
        m_tready <= stall_pat[pat_pos];
        pat_pos <= (pat_pos + 1) % 16;
    end

    task automatic send_req(logic [1:0] cmd, logic nc, int px, int py,
                            int fx, int fy, int sx, int sy,
                            logic typed = 1'b0, logic m = 1'b0, logic [1:0] st = ST_OK);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        tag_q.push_back('{typed, m, st});
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, sy[14:0], sx[14:0], fy[14:0], fx[14:0],
                    py[11:0], px[11:0], nc, cmd};
        do @(posedge aclk); while (!s_tready);
        n_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_access(logic wr, logic [2:0] addr, int val);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= wr; paddr <= addr; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (!wr && prdata[12:0] != val[12:0])
            report_mismatch("register readback", prdata[12:0], val[12:0]);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic set_size(int w, int h);
        apb_access(1'b1, {REG_IMAGE_WIDTH, 2'b00}, w);
        img_w = w & 13'h1FFF;
        apb_access(1'b1, {REG_IMAGE_HEIGHT, 2'b00}, h);
        img_h = h & 13'h1FFF;
        apb_access(1'b0, {REG_IMAGE_WIDTH, 2'b00}, img_w);
        apb_access(1'b0, {REG_IMAGE_HEIGHT, 2'b00}, img_h);
    endtask

    function automatic int rnd_coord(bit wide);
        return wide ? $urandom_range(0, 32767) : $urandom_range(0, 110 * 256);
    endfunction

    function automatic int rnd_pix(int size);
        int hi;
        hi = (size == 0) ? 2 : ((size * 21 / 20 > 4095) ? 4095 : size * 21 / 20);
        return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, hi);
    endfunction

    // one load of a zone set followed by pixel tests, with the odd random request mixed in
    task automatic run_scene(int nz, int max_nv, int ntest);
        int l, t, nv;
        bit wide;
        send_req(CMD_CLEAR, 1'($urandom_range(0, 1)), $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom);
        for (int z = 0; z < nz; z++) begin
            wide = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 2) == 0) begin
                l = rnd_coord(wide);
                t = rnd_coord(wide);
                send_req(CMD_RECT, 1'($urandom_range(0, 1)), $urandom, $urandom, l, t,
                         l + $urandom_range(0, 60 * 256), t + $urandom_range(0, 60 * 256));
            end else begin
                nv = $urandom_range(1, max_nv);
                for (int v = 0; v < nv; v++)
                    send_req(CMD_VERTEX, v == 0 ? ($urandom_range(0, 3) != 0)
                                                : ($urandom_range(0, 30) == 0),
                             $urandom, $urandom, rnd_coord(wide), rnd_coord(wide),
                             $urandom, $urandom);
            end
        end
        for (int k = 0; k < ntest; k++) begin
            if ($urandom_range(0, 9) == 0)
                send_req(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                         $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            else
                send_req(CMD_TEST, 1'($urandom_range(0, 1)), rnd_pix(img_w), rnd_pix(img_h),
                         $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    row_t dir_tab [17] = '{
        '{CMD_TEST,   1'b0, 12'd0,    12'd0,    15'd0,     15'd0,     15'd0, 15'd0,
          1'b1, 1'b1, ST_OK},
        '{CMD_TEST,   1'b1, 12'd4095, 12'd4095, 15'h7FFF,  15'h7FFF,  15'h7FFF, 15'h7FFF,
          1'b1, 1'b1, ST_OK},
        '{CMD_VERTEX, 1'b0, 12'd0,    12'd0,    15'd2560,  15'd2560,  15'd0, 15'd0,
          1'b1, 1'b0, ST_OK},
        '{CMD_VERTEX, 1'b0, 12'd0,    12'd0,    15'd23040, 15'd2560,  15'd0, 15'd0,
          1'b1, 1'b0, ST_OK},
        '{CMD_VERTEX, 1'b0, 12'd0,    12'd0,    15'd12800, 15'd23040, 15'd0, 15'd0,
          1'b1, 1'b0, ST_OK},
        '{CMD_TEST,   1'b0, 12'd320,  12'd240,  15'd0, 15'd0, 15'd0, 15'd0, 1'b0, 1'b0, ST_OK},
        '{CMD_TEST,   1'b0, 12'd0,    12'd0,    15'd0, 15'd0, 15'd0, 15'd0, 1'b0, 1'b0, ST_OK},
        '{CMD_RECT,   1'b0, 12'd0,    12'd0,    15'd5120,  15'd5120,  15'd20480, 15'd20480,
          1'b1, 1'b0, ST_OK},
        '{CMD_VERTEX, 1'b0, 12'd0,    12'd0,    15'h7FFF,  15'd0,     15'd0, 15'd0,
          1'b1, 1'b0, ST_OK},
        '{CMD_VERTEX, 1'b1, 12'd0,    12'd0,    15'd0,     15'h7FFF,  15'd0, 15'd0,
          1'b1, 1'b0, ST_OK},
        '{CMD_TEST,   1'b0, 12'd4095, 12'd0,    15'd0, 15'd0, 15'd0, 15'd0, 1'b0, 1'b0, ST_OK},
        '{CMD_RECT,   1'b1, 12'd0,    12'd0,    15'd0, 15'd0, 15'd0, 15'd0, 1'b1, 1'b0, ST_OK},
        '{CMD_RECT,   1'b0, 12'd0,    12'd0,    15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF,
          1'b1, 1'b0, ST_OK},
        '{CMD_TEST,   1'b0, 12'd640,  12'd480,  15'd0, 15'd0, 15'd0, 15'd0, 1'b0, 1'b0, ST_OK},
        '{CMD_CLEAR,  1'b1, 12'hFFF,  12'hFFF,  15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF,
          1'b1, 1'b0, ST_OK},
        '{CMD_TEST,   1'b0, 12'd100,  12'd100,  15'd0, 15'd0, 15'd0, 15'd0, 1'b1, 1'b1, ST_OK},
        '{CMD_VERTEX, 1'b1, 12'd0,    12'd0,    15'd2560, 15'd12800, 15'd0, 15'd0,
          1'b1, 1'b0, ST_OK}
    };

    int sizes [6][2] = '{'{640, 480}, '{1, 1}, '{4096, 4096}, '{0, 0},
                         '{100, 8191}, '{0, 0}};

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        gap_max = 4;
        stall_pat = 16'hB6DB;

        foreach (dir_tab[i])
            send_req(dir_tab[i].cmd, dir_tab[i].nc, dir_tab[i].px, dir_tab[i].py,
                     dir_tab[i].fx, dir_tab[i].fy, dir_tab[i].sx, dir_tab[i].sy,
                     dir_tab[i].typed, dir_tab[i].mask, dir_tab[i].st);
        // horizontal two-vertex polygon
        send_req(CMD_VERTEX, 1'b0, 0, 0, 23040, 12800, 0, 0);
        send_req(CMD_TEST, 1'b0, 320, 240, 0, 0, 0, 0);
        send_req(CMD_TEST, 1'b0, 64, 240, 0, 0, 0, 0);

        sizes[5][0] = $urandom_range(1, 4096);
        sizes[5][1] = $urandom_range(1, 4096);
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            set_size(sizes[ph][0], sizes[ph][1]);
            gap_max = (ph % 3 == 0) ? 0 : $urandom_range(2, 12);
            stall_pat = (ph % 3 == 1) ? 16'hFFFF : 16'($urandom);
            stall_pat[0] = 1'b1;
            // fill the zone table, then load long polygons into the vertex store
            if (ph == 1) run_scene(19, 3, 6);
            if (ph == 2) run_scene(9, 40, 5);
            while (n_sent < 20 + (ph + 1) * 205)
                run_scene($urandom_range(0, 6), 8, $urandom_range(8, 30));
        end

        drain();
        $display("Sent %0d requests incl. %0d pixel tests (%0d inside) over 6 image sizes;",
                 n_sent, n_tests, n_inside);
        $display("zone-table-full responses %0d, vertex-store-full responses %0d",
                 n_zfull, n_vfull);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
